@@ hdl/cms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types and constants of the count-min sketch: controller states,
// command and status bundles, field widths and opcodes.
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam int DATA_W     = 32;
    localparam int KEY_W      = 32;
    localparam int CFG_REGS   = 8;
    localparam int CFG_IDX_W  = 3;

    // modulo unit: reciprocal product, quotient, raw remainder, correction
    localparam int MOD_CYCLES = 4;
    localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

    localparam logic OP_UPDATE   = 1'b0;
    localparam logic OP_ESTIMATE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_MOD,
        ST_READ,
        ST_EXEC
    } cms_state_t;

    typedef struct packed {
        logic clr_en;
        logic load;
        logic mul_en;
        logic add_en;
        logic mod_en;
        logic rd_en;
        logic exec_en;
    } cms_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic out_free;
    } cms_sts_t;

endpackage

@@ hdl/cms_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_datapath
// Config registers, per-row hash lanes, counter banks, min/total logic and
// the result register.
// ----------------------------------------------------------------------------
module cms_datapath
    import cms_pkg::*;
#(
    parameter int ROWS = 4,
    parameter int COLS = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cms_cmd_t                 cmd,
    output cms_sts_t                 sts,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [DATA_W-1:0]        cfg_wr_data,
    input  logic                     s_opcode,
    input  logic [KEY_W-1:0]         s_item_key,
    input  logic signed [DATA_W-1:0] s_count_delta,
    input  logic                     m_ready,
    output logic                     m_valid,
    output logic signed [DATA_W-1:0] m_estimate_value,
    output logic signed [DATA_W-1:0] m_total_count
);

    localparam int IW = $clog2(COLS);
    localparam logic [IW:0]   COLS_W   = COLS[IW:0];
    localparam logic [IW-1:0] LAST_COL = IW'(COLS - 1);

    // floor(2^(32+IW) / COLS) lies in [2^32, 2^33); only its low word is
    // multiplied, the implied top bit is added as the hash itself
    localparam logic [63:0]      RECIP_FULL = (64'd1 << (KEY_W + IW)) / 64'(COLS);
    localparam logic [KEY_W-1:0] RECIP_LO   = RECIP_FULL[KEY_W-1:0];

    logic [DATA_W-1:0]        cfg_reg [CFG_REGS];
    logic                     op_reg;
    logic [KEY_W-1:0]         key_reg;
    logic signed [DATA_W-1:0] delta_reg;
    logic signed [DATA_W-1:0] total_reg;
    logic [IW-1:0]            clr_addr_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] est_out_reg;
    logic signed [DATA_W-1:0] total_out_reg;

    logic signed [DATA_W-1:0] rd_data [ROWS];
    logic signed [DATA_W-1:0] est_min;
    logic signed [DATA_W-1:0] total_sum;

    // config registers, written any time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CFG_REGS; i++) begin
                cfg_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            cfg_reg[cfg_wr_index] <= cfg_wr_data;
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_opcode;
            key_reg   <= s_item_key;
            delta_reg <= s_count_delta;
        end
    end

    // clearing sweep address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_en) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    for (genvar r = 0; r < ROWS; r++) begin : g_row
        localparam logic [CFG_IDX_W-1:0] MULT_IDX = CFG_IDX_W'(2 * r);
        localparam logic [CFG_IDX_W-1:0] ADD_IDX  = CFG_IDX_W'(2 * r + 1);

        logic [DATA_W-1:0]        mem [COLS];
        logic [KEY_W-1:0]         prod_reg;
        logic [KEY_W-1:0]         hash_reg;
        logic [2*KEY_W-1:0]       recip_prod;
        logic [KEY_W-1:0]         recip_hi_reg;
        logic [KEY_W:0]           quot_sum;
        logic [IW:0]              quot_reg;
        logic [IW:0]              rem_raw_reg;
        logic [IW:0]              rem_fix;
        logic [IW-1:0]            rem_reg;
        logic signed [DATA_W-1:0] rd_reg;

        // remainder by COLS via the reciprocal: the quotient estimate is at
        // most one low, so the raw remainder is below 2*COLS and one
        // conditional subtract finishes it; only the low IW+1 bits matter
        assign recip_prod = {{KEY_W{1'b0}}, hash_reg} * {{KEY_W{1'b0}}, RECIP_LO};
        assign quot_sum   = {1'b0, hash_reg} + {1'b0, recip_hi_reg};

        always_comb begin
            if (rem_raw_reg >= COLS_W) begin
                rem_fix = rem_raw_reg - COLS_W;
            end else begin
                rem_fix = rem_raw_reg;
            end
        end

        // hash_reg holds during the modulo steps, so each stage settles in the
        // cycle after the one before it
        always_ff @(posedge aclk) begin
            if (cmd.mul_en) begin
                prod_reg <= cfg_reg[MULT_IDX] * key_reg;
            end
            if (cmd.add_en) begin
                hash_reg <= prod_reg + cfg_reg[ADD_IDX];
            end
            if (cmd.mod_en) begin
                recip_hi_reg <= recip_prod[2*KEY_W-1:KEY_W];
                quot_reg     <= quot_sum[2*IW:IW];
                rem_raw_reg  <= hash_reg[IW:0] - quot_reg * COLS_W;
                rem_reg      <= rem_fix[IW-1:0];
            end
        end

        // counter bank: one write and one registered read per cycle
        always_ff @(posedge aclk) begin
            if (cmd.clr_en) begin
                mem[clr_addr_reg] <= '0;
            end else if (cmd.exec_en && op_reg == OP_UPDATE) begin
                mem[rem_reg] <= rd_reg + delta_reg;
            end
            if (cmd.rd_en) begin
                rd_reg <= mem[rem_reg];
            end
        end

        assign rd_data[r] = rd_reg;
    end

    always_comb begin
        est_min = 32'sh7FFF_FFFF;
        for (int r = 0; r < ROWS; r++) begin
            if (rd_data[r] < est_min) begin
                est_min = rd_data[r];
            end
        end
    end

    assign total_sum = total_reg + delta_reg;

    // running total and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (cmd.exec_en) begin
            out_valid_reg <= 1'b1;
            if (op_reg == OP_UPDATE) begin
                total_reg <= total_sum;
            end
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec_en) begin
            if (op_reg == OP_UPDATE) begin
                est_out_reg   <= '0;
                total_out_reg <= total_sum;
            end else begin
                est_out_reg   <= est_min;
                total_out_reg <= total_reg;
            end
        end
    end

    assign sts.clr_done    = (clr_addr_reg == LAST_COL);
    assign sts.out_free    = !out_valid_reg || m_ready;

    assign m_valid          = out_valid_reg;
    assign m_estimate_value = est_out_reg;
    assign m_total_count    = total_out_reg;

endmodule

@@ hdl/cms_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_ctrl
// Sequencer: clearing sweep, then per item multiply, add, modulo, read and
// execute steps.
// ----------------------------------------------------------------------------
module cms_ctrl
    import cms_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cms_sts_t sts,
    output cms_cmd_t cmd
);

    localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(MOD_CYCLES - 1);

    cms_state_t           state_reg;
    cms_state_t           state_next;
    logic [MOD_CNT_W-1:0] mod_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            mod_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_ADD) begin
                mod_cnt_reg <= '0;
            end else if (state_reg == ST_MOD) begin
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (sts.clr_done) state_next = ST_IDLE;
            ST_IDLE:  if (s_valid) state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD:   state_next = ST_MOD;
            ST_MOD:   if (mod_cnt_reg == MOD_LAST) state_next = ST_READ;
            ST_READ:  state_next = ST_EXEC;
            ST_EXEC:  if (sts.out_free) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.clr_en = 1'b1;
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_MUL:   cmd.mul_en  = 1'b1;
            ST_ADD:   cmd.add_en  = 1'b1;
            ST_MOD:   cmd.mod_en  = 1'b1;
            ST_READ:  cmd.rd_en   = 1'b1;
            ST_EXEC:  cmd.exec_en = sts.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

@@ hdl/count_min_sketch.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// count_min_sketch
// Count-min sketch over integer keys: ROWS banks of COLS signed counters,
// per-row multiply/add hash, update and estimate operations.
// ----------------------------------------------------------------------------
// Usage notes:
//   Input channel s_*: opcode (update or estimate), key and signed delta,
//   valid/ready. Result channel m_*: estimate (zero on update) and the
//   running total after the item, valid/ready.
//   Config port cfg_wr_*: index 0..7 selects row mult/add, no read-back.
//   Write only while the block is idle.
//   The sequencer works on one item at a time: multiply, add, the modulo
//   unit (reciprocal product, quotient, raw remainder, correction), one
//   bank read, one execute step that registers the result; a new item
//   is taken only after the execute step of the last one.
//   All rows run in parallel lanes, each with its own counter bank.
//   Reset: config and total cleared; then a clearing pass zeroes the
//   counter banks with s_ready low. Config writes are taken during the
//   pass.
//   Stall: the result sits in an output register; the next item can be
//   taken meanwhile, and its execute step waits until the register frees.
// ----------------------------------------------------------------------------
module count_min_sketch
    import cms_pkg::*;
#(
    parameter int ROWS = 4,
    parameter int COLS = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // config write port
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [DATA_W-1:0]        cfg_wr_data,
    // input channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_opcode,
    input  logic [KEY_W-1:0]         s_item_key,
    input  logic signed [DATA_W-1:0] s_count_delta,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_estimate_value,
    output logic signed [DATA_W-1:0] m_total_count
);

    cms_cmd_t cmd;
    cms_sts_t sts;

    cms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cms_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_opcode         (s_opcode),
        .s_item_key       (s_item_key),
        .s_count_delta    (s_count_delta),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_estimate_value (m_estimate_value),
        .m_total_count    (m_total_count)
    );

    // one item in flight: an input transfer makes the block busy
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready
    ) else $error("s_ready high right after an input transfer");

    // a result is never loaded over one that has not been taken
    a_no_overwrite: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid
    ) else $error("pending result dropped");

    // a new result only appears while the sequencer is busy
    a_result_needs_item: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready)
    ) else $error("result without an item in flight");

endmodule
